### rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;

  // field widths
  localparam int TIME_BITS      = 48;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int BUS_W          = 15;
  localparam int RAW_W          = 16;
  localparam int GAIN_W         = 15;
  localparam int GAP_W          = 20;
  localparam int DIFF_W         = RAW_W + 1;
  localparam int CORR_W         = 18;
  localparam int PWR_W          = 33;
  localparam int SUM_W          = PWR_W + 1;
  localparam int ENERGY_W       = 64;
  localparam int SEQ_W          = 32;

  // shared bit-serial multiplier: signed multiplicand, unsigned multiplier
  localparam int MPL_W = GAP_W;
  localparam int MUL_W = SUM_W + MPL_W;
  localparam int CNT_W = $clog2(MPL_W);
  localparam int SH_W  = MUL_W - GAIN_FRAC_BITS;

  localparam logic signed [SH_W-1:0] SH_MAX = SH_W'((2 ** (CORR_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SH_MIN = SH_W'(-(2 ** (CORR_W - 1)));

  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  // status flag limits
  localparam logic signed [RAW_W-1:0] CUR_SAT_POS   = 16'sd32700;
  localparam logic signed [RAW_W-1:0] CUR_SAT_NEG   = -16'sd32700;
  localparam logic signed [RAW_W-1:0] SHUNT_LIM_POS = 16'sd30000;
  localparam logic signed [RAW_W-1:0] SHUNT_LIM_NEG = -16'sd30000;
  localparam logic [BUS_W-1:0]        BUS_UV_LOW    = 15'd160;
  localparam logic [BUS_W-1:0]        BUS_UV_HIGH   = 15'd3800;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT      = 2'd2;
  localparam int CFG_DATA_W = GAP_W;

  localparam logic signed [RAW_W-1:0] OFFSET_RESET = '0;
  localparam logic [GAIN_W-1:0]       GAIN_RESET   = 15'd16384;
  localparam logic [GAP_W-1:0]        GAP_RESET    = 20'd30000;

  // operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } smul_stat_t;

endpackage
`default_nettype wire

### rtl/pse_smul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module pse_smul import pse_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [MUL_W-1:0]   mcand_i,
  input  wire logic [MPL_W-1:0]   mplier_i,
  output smul_stat_t              stat_o,
  output logic [MUL_W-1:0]        product_o
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(MPL_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_W-1:0] mc_q, mc_d;
  logic [MPL_W-1:0] mp_q, mp_d;
  logic [MUL_W-1:0] acc_q, acc_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mc_d   = mcand_i;
      mp_d   = mplier_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d  = {mc_q[MUL_W-2:0], 1'b0};
      mp_d  = {1'b0, mp_q[MPL_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = acc_q;

endmodule
`default_nettype wire

### rtl/power_sample_energy_integrator.sv
// Sample transaction: the result is loaded into the output register in S_ACC
// after two products on a first sample or a gap, three when the interval is
// integrated; the next transaction is taken once the sequencer is back in
// S_IDLE, later still while a finished result waits on a stalled, full output
// register. Products run in turn on one bit-serial multiplier. Restart: no result.
// Reset (rst_ni low, async) clears run state and loads the register defaults.
`default_nettype none
module power_sample_energy_integrator import pse_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data_i,
  // sample channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [BUS_W-1:0]            bus_raw_i,
  input  wire logic signed [RAW_W-1:0]     shunt_raw_i,
  input  wire logic signed [RAW_W-1:0]     current_raw_i,
  input  wire logic [TIME_BITS-1:0]        time_us_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [SEQ_W-1:0]                 sequence_res_o,
  output logic signed [CORR_W-1:0]         corrected_current_o,
  output logic signed [PWR_W-1:0]          power_o,
  output logic signed [ENERGY_W-1:0]       energy_o,
  output logic                             current_clip_o,
  output logic                             shunt_high_o,
  output logic                             undervoltage_o,
  output logic                             span_skipped_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_M1   = 3'd1;  // (raw - offset) * gain
  localparam logic [2:0] S_CUR  = 3'd2;  // launch bus * current, check spacing
  localparam logic [2:0] S_M2   = 3'd3;  // bus * corrected current
  localparam logic [2:0] S_PWR  = 3'd4;  // launch trapezoid product
  localparam logic [2:0] S_M3   = 3'd5;  // (prev + power) * spacing
  localparam logic [2:0] S_ACC  = 3'd6;  // saturating add, load output

  logic [2:0] state_q, state_d;

  // configuration registers
  logic signed [RAW_W-1:0] offset_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [GAP_W-1:0]        gap_limit_q;

  // run state
  logic [TIME_BITS-1:0]       last_time_q;
  logic                       have_prev_q;
  logic signed [PWR_W-1:0]    prev_pwr_q;
  logic signed [ENERGY_W-1:0] energy_q;
  logic [SEQ_W-1:0]           count_q;

  // per-sample working registers
  logic [BUS_W-1:0]           bus_q;
  logic [TIME_BITS-1:0]       time_q;
  logic [TIME_BITS-1:0]       delta_q;
  logic                       cur_sat_q, shunt_near_q, under_q;
  logic                       integ_q, gap_q;
  logic signed [CORR_W-1:0]   corr_q;
  logic signed [PWR_W-1:0]    pwr_q;
  logic [MUL_W-1:0]           term_q;

  // output register
  logic                       out_valid_q;
  logic [SEQ_W-1:0]           seq_out_q;
  logic signed [CORR_W-1:0]   corr_out_q;
  logic signed [PWR_W-1:0]    pwr_out_q;
  logic signed [ENERGY_W-1:0] energy_out_q;
  logic                       cur_sat_out_q, shunt_out_q, under_out_q, gap_out_q;

  // multiplier
  logic             mul_start;
  logic [MUL_W-1:0] mul_mcand;
  logic [MPL_W-1:0] mul_mplier;
  smul_stat_t       mul_stat;
  logic [MUL_W-1:0] mul_prod;

  pse_smul u_smul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .stat_o    (mul_stat),
    .product_o (mul_prod)
  );

  logic in_fire, out_fire, out_blocked, acc_fire;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SH_W-1:0]   shifted;
  logic signed [CORR_W-1:0] corr_sat;
  logic signed [SUM_W-1:0]  pwr_sum;
  logic [ENERGY_W:0]        energy_sum;
  logic signed [ENERGY_W-1:0] energy_next;
  logic                     delta_ok;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_blocked = out_valid_q && out_stall_i;
  assign acc_fire    = (state_q == S_ACC) && !out_blocked;

  // current correction: operands of the first product
  assign diff = DIFF_W'(current_raw_i) - DIFF_W'(offset_q);

  // floor shift of the gain product, clamped to the result width
  assign shifted = mul_prod[MUL_W-1:GAIN_FRAC_BITS];
  always_comb begin
    if (shifted > SH_MAX) begin
      corr_sat = SH_MAX[CORR_W-1:0];
    end else if (shifted < SH_MIN) begin
      corr_sat = SH_MIN[CORR_W-1:0];
    end else begin
      corr_sat = shifted[CORR_W-1:0];
    end
  end

  // spacing must be nonzero and within the limit
  assign delta_ok = (delta_q != '0) && (delta_q <= TIME_BITS'(gap_limit_q));

  assign pwr_sum = SUM_W'(prev_pwr_q) + SUM_W'(pwr_q);

  // 64-bit saturating accumulate, one guard bit
  assign energy_sum = {energy_q[ENERGY_W-1], energy_q}
                    + {{(ENERGY_W+1-MUL_W){term_q[MUL_W-1]}}, term_q};
  always_comb begin
    if (energy_sum[ENERGY_W] != energy_sum[ENERGY_W-1]) begin
      energy_next = energy_sum[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX;
    end else begin
      energy_next = energy_sum[ENERGY_W-1:0];
    end
  end

  // sequencer and multiplier launch
  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (operation_i == OP_SAMPLE)) begin
          mul_start  = 1'b1;
          mul_mcand  = {{(MUL_W-DIFF_W){diff[DIFF_W-1]}}, diff};
          mul_mplier = MPL_W'(gain_q);
          state_d    = S_M1;
        end
      end
      S_M1: begin
        if (mul_stat.done) begin
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        mul_start  = 1'b1;
        mul_mcand  = {{(MUL_W-CORR_W){corr_q[CORR_W-1]}}, corr_q};
        mul_mplier = MPL_W'(bus_q);
        state_d    = S_M2;
      end
      S_M2: begin
        if (mul_stat.done) begin
          state_d = S_PWR;
        end
      end
      S_PWR: begin
        if (integ_q) begin
          mul_start  = 1'b1;
          mul_mcand  = {{(MUL_W-SUM_W){pwr_sum[SUM_W-1]}}, pwr_sum};
          mul_mplier = delta_q[MPL_W-1:0];
          state_d    = S_M3;
        end else begin
          state_d = S_ACC;
        end
      end
      S_M3: begin
        if (mul_stat.done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (!out_blocked) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= OFFSET_RESET;
      gain_q      <= GAIN_RESET;
      gap_limit_q <= GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CURRENT_OFFSET: offset_q    <= cfg_data_i[RAW_W-1:0];
        REG_CURRENT_GAIN:   gain_q      <= cfg_data_i[GAIN_W-1:0];
        REG_GAP_LIMIT:      gap_limit_q <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // run state: restart clears, a finished sample advances it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      have_prev_q <= 1'b0;
      prev_pwr_q  <= '0;
      energy_q    <= '0;
      count_q     <= '0;
    end else if (in_fire && (operation_i == OP_RESTART)) begin
      last_time_q <= '0;
      have_prev_q <= 1'b0;
      prev_pwr_q  <= '0;
      energy_q    <= '0;
      count_q     <= '0;
    end else if (acc_fire) begin
      last_time_q <= time_q;
      have_prev_q <= 1'b1;
      prev_pwr_q  <= pwr_q;
      if (integ_q) begin
        energy_q <= energy_next;
      end
      count_q <= count_q + 1'b1;
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bus_q        <= bus_raw_i;
      time_q       <= time_us_i;
      delta_q      <= time_us_i - last_time_q;  // wraps modulo 2^TIME_BITS
      cur_sat_q    <= (current_raw_i >= CUR_SAT_POS) || (current_raw_i <= CUR_SAT_NEG);
      shunt_near_q <= (shunt_raw_i >= SHUNT_LIM_POS) || (shunt_raw_i <= SHUNT_LIM_NEG);
      under_q      <= (bus_raw_i > BUS_UV_LOW) && (bus_raw_i < BUS_UV_HIGH);
    end
    if ((state_q == S_M1) && mul_stat.done) begin
      corr_q <= corr_sat;
    end
    if (state_q == S_CUR) begin
      integ_q <= have_prev_q && delta_ok;
      gap_q   <= have_prev_q && !delta_ok;
    end
    if ((state_q == S_M2) && mul_stat.done) begin
      pwr_q <= mul_prod[PWR_W-1:0];
    end
    if ((state_q == S_M3) && mul_stat.done) begin
      term_q <= mul_prod;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      seq_out_q     <= count_q;
      corr_out_q    <= corr_q;
      pwr_out_q     <= pwr_q;
      energy_out_q  <= integ_q ? energy_next : energy_q;
      cur_sat_out_q <= cur_sat_q;
      shunt_out_q   <= shunt_near_q;
      under_out_q   <= under_q;
      gap_out_q     <= gap_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sequence_res_o      = seq_out_q;
  assign corrected_current_o = corr_out_q;
  assign power_o             = pwr_out_q;
  assign energy_o            = energy_out_q;
  assign current_clip_o      = cur_sat_out_q;
  assign shunt_high_o        = shunt_out_q;
  assign undervoltage_o      = under_out_q;
  assign span_skipped_o      = gap_out_q;

  // a new result only follows the accumulate state
  a_result_from_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_ACC))
    else $error("result raised outside accumulate state");

  // multiplier is never relaunched while running
  a_mul_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // restart leaves an empty run
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (operation_i == OP_RESTART)) |=>
      (count_q == '0) && !have_prev_q && (energy_q == '0))
    else $error("restart did not clear run state");

  // integration and gap are exclusive and need a previous sample
  a_gap_needs_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> !(integ_q && gap_q) && (have_prev_q || (!integ_q && !gap_q)))
    else $error("gap or integrate without previous sample");

endmodule
`default_nettype wire

### tb/sv/power_sample_energy_integrator_tb.sv
`timescale 1ns / 100ps

module power_sample_energy_integrator_tb import pse_pkg::*; ();

  // Waits that do not follow a handshake:
  // SETTLE_CYCLES covers one full sample transaction after the last
  // result, so a trailing restart is done before registers change.
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_GUARD   = 20000;
  localparam int HOLDOFF_LEN   = 600;
  localparam int FULL_RUN_LEN  = 300;
  localparam int PHASE_COUNT   = 5;
  localparam int PHASE_ITEMS   = 100;

  // Corrected current saturates to the 18-bit signed range.
  localparam longint CORR_HI = (longint'(1) <<< (CORR_W - 1)) - 1;
  localparam longint CORR_LO = -(longint'(1) <<< (CORR_W - 1));

  typedef struct packed {
    logic                    op;
    logic [BUS_W-1:0]        bus;
    logic signed [RAW_W-1:0] shunt;
    logic signed [RAW_W-1:0] cur;
    logic [TIME_BITS-1:0]    stamp;
  } sample_t;

  typedef struct packed {
    logic [SEQ_W-1:0]           seq;
    logic signed [CORR_W-1:0]   corr;
    logic signed [PWR_W-1:0]    pwr;
    logic signed [ENERGY_W-1:0] energy;
    logic                       cur_sat;
    logic                       shunt_near;
    logic                       under;
    logic                       gap;
  } reading_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_idx_i;
  logic [CFG_DATA_W-1:0]       cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        operation_i;
  logic [BUS_W-1:0]            bus_raw_i;
  logic signed [RAW_W-1:0]     shunt_raw_i;
  logic signed [RAW_W-1:0]     current_raw_i;
  logic [TIME_BITS-1:0]        time_us_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [SEQ_W-1:0]            sequence_res_o;
  logic signed [CORR_W-1:0]    corrected_current_o;
  logic signed [PWR_W-1:0]     power_o;
  logic signed [ENERGY_W-1:0]  energy_o;
  logic                        current_clip_o;
  logic                        shunt_high_o;
  logic                        undervoltage_o;
  logic                        span_skipped_o;

  power_sample_energy_integrator dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .bus_raw_i           (bus_raw_i),
    .shunt_raw_i         (shunt_raw_i),
    .current_raw_i       (current_raw_i),
    .time_us_i           (time_us_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .sequence_res_o      (sequence_res_o),
    .corrected_current_o (corrected_current_o),
    .power_o             (power_o),
    .energy_o            (energy_o),
    .current_clip_o      (current_clip_o),
    .shunt_high_o        (shunt_high_o),
    .undervoltage_o      (undervoltage_o),
    .span_skipped_o      (span_skipped_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Register copies, as last written to the block.
  logic signed [RAW_W-1:0] set_offset = OFFSET_RESET;
  logic [GAIN_W-1:0]       set_gain   = GAIN_RESET;
  logic [GAP_W-1:0]        set_gap    = GAP_RESET;

  // Run state of the energy integrator, as the block should hold it.
  logic [TIME_BITS-1:0]       run_stamp      = '0;
  logic                       run_primed     = 1'b0;
  longint                     run_prev_power = 0;
  logic signed [ENERGY_W-1:0] run_energy     = '0;
  logic [SEQ_W-1:0]           run_count      = '0;

  reading_t expected_readings[$];

  // Stimulus bookkeeping.
  logic [TIME_BITS-1:0] stamp_now    = '0;
  bit                   no_idle      = 1'b0;
  int                   hold_request = 0;

  int samples_sent      = 0;
  int restarts_sent     = 0;
  int readings_checked  = 0;
  int gap_readings      = 0;
  int saturated_energy  = 0;
  int mismatch_count    = 0;
  int stray_count       = 0;

  // --------------------------------------------------------------------------
  // Prediction: one accepted transaction in, zero or one expected reading out.
  // --------------------------------------------------------------------------
  function automatic void forecast_reading(input sample_t s);
    longint                   diff;
    longint                   corr;
    longint                   pw;
    longint                   area;
    logic [TIME_BITS-1:0]     span;
    logic signed [ENERGY_W:0] wide;
    reading_t                 r;
    if (s.op == OP_RESTART) begin
      // restart wipes the run but keeps the registers
      run_stamp      = '0;
      run_primed     = 1'b0;
      run_prev_power = 0;
      run_energy     = '0;
      run_count      = '0;
      return;
    end
    // offset, unsigned Q1.14 gain, floor via arithmetic shift, clamp to 18 bits
    diff = longint'($signed(s.cur)) - longint'($signed(set_offset));
    corr = (diff * longint'(set_gain)) >>> GAIN_FRAC_BITS;
    if (corr > CORR_HI) begin
      corr = CORR_HI;
    end else if (corr < CORR_LO) begin
      corr = CORR_LO;
    end
    pw = longint'(s.bus) * corr;

    r.gap = 1'b0;
    if (run_primed) begin
      // spacing wraps modulo 2^48 by the vector width
      span = s.stamp - run_stamp;
      if (span != '0 && span <= set_gap) begin
        // trapezoid in half units: (p_prev + p) * dt, saturating at 64 bits
        area = (run_prev_power + pw) * longint'(span);
        wide = $signed({run_energy[ENERGY_W-1], run_energy}) + $signed({area[63], area});
        if (wide > $signed({1'b0, ENERGY_MAX})) begin
          run_energy = ENERGY_MAX;
        end else if (wide < $signed({1'b1, ENERGY_MIN})) begin
          run_energy = ENERGY_MIN;
        end else begin
          run_energy = wide[ENERGY_W-1:0];
        end
      end else begin
        r.gap = 1'b1;
      end
    end

    r.seq        = run_count;
    r.corr       = corr[CORR_W-1:0];
    r.pwr        = pw[PWR_W-1:0];
    r.energy     = run_energy;
    r.cur_sat    = (s.cur >= CUR_SAT_POS) || (s.cur <= CUR_SAT_NEG);
    r.shunt_near = (s.shunt >= SHUNT_LIM_POS) || (s.shunt <= SHUNT_LIM_NEG);
    r.under      = (s.bus > BUS_UV_LOW) && (s.bus < BUS_UV_HIGH);

    run_stamp      = s.stamp;
    run_prev_power = pw;
    run_primed     = 1'b1;
    run_count      = run_count + 1'b1;
    expected_readings.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, plus a counted hold-off when one is requested.
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int hold_len;
    int held;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        held         = 0;
        out_stall_i <= 1'b1;
        while (held < hold_len) begin
          @(posedge clk_i);
          held++;
        end
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 23);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < 10) begin
        $display("%0t: reading %0d field %s expected %h got %h",
                 $realtime, readings_checked, name, want, got);
      end
      mismatch_count++;
    end
  endtask

  // Every accepted result transaction is checked against the oldest forecast.
  always @(posedge clk_i) begin : reading_check
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        if (stray_count < 10) begin
          $display("%0t: result transaction with nothing expected, seq %0d",
                   $realtime, sequence_res_o);
        end
        stray_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("sequence_res", want.seq, sequence_res_o);
        check_field("corrected_current", want.corr, corrected_current_o);
        check_field("power", want.pwr, power_o);
        check_field("energy", want.energy, energy_o);
        check_field("current_clip", want.cur_sat, current_clip_o);
        check_field("shunt_high", want.shunt_near, shunt_high_o);
        check_field("undervoltage", want.under, undervoltage_o);
        check_field("span_skipped", want.gap, span_skipped_o);
        readings_checked++;
        if (want.gap) gap_readings++;
        if (want.energy == ENERGY_MAX || want.energy == ENERGY_MIN) saturated_energy++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------
  // Offer one transaction and hold it until the block takes it. Called at a
  // rising edge; returns at the edge of acceptance.
  task automatic offer(input sample_t s);
    if (!no_idle && $urandom_range(99) < 23) begin
      // idle stretches up to about one transaction long, so gaps land on
      // every phase of the serial multiply
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= s.op;
    bus_raw_i     <= s.bus;
    shunt_raw_i   <= s.shunt;
    current_raw_i <= s.cur;
    time_us_i     <= s.stamp;
    do @(posedge clk_i); while (in_stall_o);
    forecast_reading(s);
    if (s.op == OP_RESTART) restarts_sent++;
    else samples_sent++;
  endtask

  // Measurement transaction, timestamp advanced by 'spacing'.
  task automatic sample_at(input logic [BUS_W-1:0] bus, input logic signed [RAW_W-1:0] shunt,
                           input logic signed [RAW_W-1:0] cur,
                           input logic [TIME_BITS-1:0] spacing);
    sample_t s;
    stamp_now = stamp_now + spacing;
    s.op      = OP_SAMPLE;
    s.bus     = bus;
    s.shunt   = shunt;
    s.cur     = cur;
    s.stamp   = stamp_now;
    offer(s);
  endtask

  // Restart: payload fields are don't-care, so fill them with noise.
  task automatic restart_run();
    sample_t s;
    s.op    = OP_RESTART;
    s.bus   = BUS_W'($urandom);
    s.shunt = RAW_W'($urandom);
    s.cur   = RAW_W'($urandom);
    s.stamp = {16'($urandom), 32'($urandom)};
    offer(s);
  endtask

  // Drop valid, let every forecast come back, then give any trailing
  // restart time to finish before registers are touched.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0 && waited < DRAIN_GUARD) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges; block must be idle.
  task automatic load_settings(input logic signed [RAW_W-1:0] offset,
                               input logic [GAIN_W-1:0] gain,
                               input logic [GAP_W-1:0] gap);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CURRENT_OFFSET;
    cfg_data_i <= CFG_DATA_W'($unsigned(offset));
    @(posedge clk_i);
    cfg_idx_i  <= REG_CURRENT_GAIN;
    cfg_data_i <= CFG_DATA_W'(gain);
    @(posedge clk_i);
    cfg_idx_i  <= REG_GAP_LIMIT;
    cfg_data_i <= CFG_DATA_W'(gap);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    set_offset = offset;
    set_gain   = gain;
    set_gap    = gap;
  endtask

  // Random field values, biased toward the flag thresholds and extremes.
  function automatic logic signed [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return $urandom_range(1) ? RAW_W'($urandom_range(32690, 32767))
                                  : -RAW_W'($urandom_range(32690, 32768));
      3: return $urandom_range(1) ? RAW_W'($urandom_range(29990, 30010))
                                  : -RAW_W'($urandom_range(29990, 30010));
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [BUS_W-1:0] pick_bus();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return BUS_W'($urandom_range(150, 170));
      3: return BUS_W'($urandom_range(3790, 3810));
      default: return BUS_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [RAW_W-1:0] pick_offset();
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return RAW_W'($urandom_range(400)) - 16'sd200;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return GAIN_RESET;
      1: return 15'd8192;
      2: return 15'd24576;
      3: return '1;
      4: return '0;
      default: return GAIN_W'($urandom_range(8192, 24576));
    endcase
  endfunction

  function automatic logic [GAP_W-1:0] pick_gap();
    case ($urandom_range(6))
      0: return '0;
      1: return 20'd1;
      2: return '1;
      3: return GAP_RESET;
      default: return GAP_W'($urandom_range(1, 1000000));
    endcase
  endfunction

  // Mostly in-limit spacing so energy keeps integrating; the rest are zero
  // spacing, over-limit gaps, wild jumps (which also wrap) and restarts.
  task automatic random_item();
    int                   roll;
    logic [TIME_BITS-1:0] spacing;
    roll = $urandom_range(99);
    if (roll < 3) begin
      restart_run();
      return;
    end
    if (roll < 10) begin
      spacing = '0;
    end else if (roll < 18) begin
      spacing = set_gap + $urandom_range(1, 5000);
    end else if (roll < 21) begin
      spacing = {16'($urandom), 32'($urandom)};
    end else begin
      spacing = $urandom_range(1, (set_gap == 0) ? 1 : set_gap);
    end
    sample_at(pick_bus(), pick_raw(), pick_raw(), spacing);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default registers: flag thresholds, first sample, spacing at / above the
  // limit, zero spacing, restart, and a timestamp wrap.
  task automatic test_directed_corners();
    sample_at(15'd0, 16'sd0, 16'sd0, 48'd1000);
    sample_at(15'd32767, 16'sd32767, 16'sd32767, TIME_BITS'(GAP_RESET));
    sample_at(15'd161, -16'sd32768, -16'sd32768, TIME_BITS'(GAP_RESET) + 1);
    sample_at(15'd3799, 16'sd30000, 16'sd32700, 48'd0);
    sample_at(15'd3800, -16'sd30000, -16'sd32700, 48'd1);
    sample_at(15'd160, 16'sd29999, 16'sd32699, 48'd1);
    sample_at(15'd12000, -16'sd29999, -16'sd32699, 48'd500);
    restart_run();
    // first sample after restart sits just below the wrap point
    stamp_now = {TIME_BITS{1'b1}} - 99;
    sample_at(15'd20000, 16'sd5, 16'sd1000, 48'd0);
    sample_at(15'd20000, -16'sd5, -16'sd1000, 48'd150);
    sample_at(15'd7, 16'sd1, -16'sd1, 48'd1);
    wait_drained();
  endtask

  // Register extremes: tiny gain with floor on negatives, gap limit zero,
  // widest gap limit, gain zero; defaults restored at the end.
  task automatic test_register_extremes();
    load_settings(16'sd32767, 15'd1, 20'd1);
    sample_at(15'd32767, 16'sd100, -16'sd32768, 48'd1);
    sample_at(15'd1, 16'sd0, 16'sd32767, 48'd1);
    sample_at(15'd5, 16'sd0, 16'sd0, 48'd2);
    wait_drained();
    load_settings(-16'sd32768, 15'd32767, 20'd0);
    sample_at(15'd32767, 16'sd0, 16'sd32767, 48'd1);
    sample_at(15'd32767, 16'sd0, -16'sd32768, 48'd5);
    wait_drained();
    load_settings(-16'sd5, 15'd0, 20'hFFFFF);
    sample_at(15'd1000, 16'sd0, 16'sd1234, 48'hFFFFF);
    sample_at(15'd1000, 16'sd0, -16'sd1, 48'h100000);
    wait_drained();
    load_settings(OFFSET_RESET, GAIN_RESET, GAP_RESET);
  endtask

  // Result side holds off for a long counted stretch while samples keep
  // coming, so the block backs up and stalls its input.
  task automatic test_output_holdoff();
    int k;
    hold_request = HOLDOFF_LEN;
    for (k = 0; k < 10; k++) random_item();
    wait_drained();
  endtask

  // Largest power at the widest spacing with no idling on either side: a long
  // unbroken stretch of full-size trapezoid products into the energy total.
  task automatic test_full_rate_run();
    int k;
    load_settings(-16'sd32768, 15'd32767, 20'hFFFFF);
    no_idle = 1'b1;
    restart_run();
    for (k = 0; k < FULL_RUN_LEN; k++) begin
      sample_at(15'd32767, pick_raw(), 16'sd32767, 48'hFFFFF);
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Several random register settings, each followed by a batch of samples.
  task automatic test_random_settings();
    int phase;
    int k;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      load_settings(pick_offset(), pick_gain(), pick_gap());
      for (k = 0; k < PHASE_ITEMS; k++) random_item();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_CURRENT_OFFSET;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    operation_i   <= OP_SAMPLE;
    bus_raw_i     <= '0;
    shunt_raw_i   <= '0;
    current_raw_i <= '0;
    time_us_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_register_extremes();
    test_output_holdoff();
    test_full_rate_run();
    test_random_settings();
    wait_drained();

    $display("Covered %0d samples and %0d restarts over %0d register settings;",
             samples_sent, restarts_sent, PHASE_COUNT + 5);
    $display("checked %0d readings, %0d with a skipped interval, %0d at saturated energy.",
             readings_checked, gap_readings, saturated_energy);
    if (mismatch_count == 0 && stray_count == 0 && expected_readings.size() == 0) begin
      $display("power_sample_energy_integrator regression: pass");
    end else begin
      $display("power_sample_energy_integrator regression: fail");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run (~850 transactions).
  initial begin
    #40_000_000;
    $display("power_sample_energy_integrator regression: fail");
    $finish;
  end

endmodule
